// File: hw/rtl/uarf_pkg.sv
// Shared types and constants for the UDP/ARP receive filter.
// Used by the configuration registers, the frame parser and the top level.
// Depends on nothing.
package uarf_pkg;

	localparam int MAC_W = 48;
	localparam int IP_W = 32;
	localparam int PORT_W = 16;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_INDEX_W = 2;

	localparam logic [IP_W-1:0] LOCAL_IP_RESET = 32'h0A0A_0501;
	localparam logic [PORT_W-1:0] LOCAL_PORT_RESET = 16'd20000;

	localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0] PROTO_UDP = 8'h11;

	localparam logic [5:0] IP_HDR_MIN = 6'd20;

	localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_MAC = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_IP = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_PORT = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_UDP = 2'd3;

	typedef enum logic [2:0] {
		ST_PENDING,
		ST_ARP_LEARNED,
		ST_UDP_OK,
		ST_MAC_DROP,
		ST_TYPE_DROP,
		ST_IP_DROP,
		ST_CSUM_DROP,
		ST_PORT_DROP
	} status_t;

	typedef enum logic [1:0] {
		KIND_UNKNOWN,
		KIND_ARP,
		KIND_IPV4
	} kind_t;

	typedef struct packed {
		logic [MAC_W-1:0] local_mac;
		logic [IP_W-1:0] local_ip;
		logic [PORT_W-1:0] local_port;
		logic accept_udp;
	} cfg_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic payload_valid;
		logic frame_done;
		status_t frame_status;
		logic [MAC_W-1:0] remote_mac;
		logic [15:0] payload_length;
	} result_t;

endpackage

// File: hw/rtl/uarf_cfg_regs.sv
// Configuration registers of the UDP/ARP receive filter.
// Depends on uarf_pkg for the register indexes, reset values and cfg_t.
module uarf_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [uarf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [uarf_pkg::CFG_DATA_W-1:0] cfg_data,
	output uarf_pkg::cfg_t cfg
);

	uarf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_mac <= '0;
			cfg_q.local_ip <= uarf_pkg::LOCAL_IP_RESET;
			cfg_q.local_port <= uarf_pkg::LOCAL_PORT_RESET;
			cfg_q.accept_udp <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				uarf_pkg::CFG_LOCAL_MAC: cfg_q.local_mac <= cfg_data[uarf_pkg::MAC_W-1:0];
				uarf_pkg::CFG_LOCAL_IP: cfg_q.local_ip <= cfg_data[uarf_pkg::IP_W-1:0];
				uarf_pkg::CFG_LOCAL_PORT: cfg_q.local_port <= cfg_data[uarf_pkg::PORT_W-1:0];
				uarf_pkg::CFG_ACCEPT_UDP: cfg_q.accept_udp <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/uarf_parser.sv
// Frame parser: per-frame state and the single-pass decision logic for one byte.
// Depends on uarf_pkg for the status codes, frame kinds, cfg_t and result_t.
module uarf_parser #(
	parameter int MAX_FRAME_BYTES = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] frame_byte,
	input logic frame_end,
	input uarf_pkg::cfg_t cfg,
	output uarf_pkg::result_t result
);

	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int PW = 17;

	logic [IDX_W-1:0] idx_q, idx_n;
	logic [47:0] shift_q, shift_n;
	logic [15:0] csum_q, csum_n;
	logic [5:0] hlen_q, hlen_n;
	logic [15:0] udp_q, udp_n;
	uarf_pkg::status_t drop_q, drop_n;
	uarf_pkg::kind_t kind_q, kind_n;
	logic [47:0] mac_q, mac_n;

	always_comb begin
		logic [PW-1:0] p;
		logic [PW-1:0] n;
		logic [PW-1:0] hend;
		logic [PW-1:0] start;
		logic [PW-1:0] u;
		logic [15:0] plen_q;
		logic [15:0] plen_n;
		logic [5:0] hl;
		logic [2:0] mac_sel;
		logic [1:0] ip_sel;
		logic [7:0] mac_byte;
		logic [7:0] ip_byte;
		logic [16:0] sum1;
		logic [16:0] sum2;
		uarf_pkg::status_t trunc;

		idx_n = idx_q;
		shift_n = shift_q;
		csum_n = csum_q;
		hlen_n = hlen_q;
		udp_n = udp_q;
		drop_n = drop_q;
		kind_n = kind_q;
		mac_n = mac_q;
		result = '0;

		p = {{(PW-IDX_W){1'b0}}, idx_q};
		plen_q = (udp_q >= 16'd8) ? udp_q - 16'd8 : 16'd0;
		start = PW'(22) + {{(PW-6){1'b0}}, hlen_q};
		hend = PW'(14) + {{(PW-6){1'b0}}, hlen_q};
		u = '0;
		hl = '0;
		mac_sel = 3'd5 - p[2:0];
		ip_sel = 2'd1 - p[1:0];
		mac_byte = cfg.local_mac[{mac_sel, 3'b000} +: 8];
		ip_byte = cfg.local_ip[{ip_sel, 3'b000} +: 8];
		sum1 = '0;
		sum2 = '0;

		if (step && idx_q < IDX_W'(MAX_FRAME_BYTES)) begin
			idx_n = idx_q + IDX_W'(1);
			if (!(kind_q == uarf_pkg::KIND_ARP && p >= PW'(28))) begin
				shift_n = {shift_q[39:0], frame_byte};
			end
			if (drop_q == uarf_pkg::ST_UDP_OK) begin
				result.payload_valid = (p >= start) && ((p - start) < {1'b0, plen_q});
			end else if (drop_q == uarf_pkg::ST_PENDING) begin
				if (p < PW'(6)) begin
					if (frame_byte != mac_byte) drop_n = uarf_pkg::ST_MAC_DROP;
				end else if (p == PW'(13)) begin
					if (shift_n[15:0] == uarf_pkg::ETH_TYPE_ARP) begin
						kind_n = uarf_pkg::KIND_ARP;
					end else if (shift_n[15:0] == uarf_pkg::ETH_TYPE_IPV4 && cfg.accept_udp) begin
						kind_n = uarf_pkg::KIND_IPV4;
					end else begin
						drop_n = uarf_pkg::ST_TYPE_DROP;
					end
				end else if (p > PW'(13) && kind_q == uarf_pkg::KIND_ARP) begin
					if (p >= PW'(38) && p <= PW'(41)) begin
						if (frame_byte != ip_byte) begin
							drop_n = uarf_pkg::ST_IP_DROP;
						end else if (p == PW'(41)) begin
							mac_n = shift_n;
							drop_n = uarf_pkg::ST_ARP_LEARNED;
						end
					end
				end else if (p > PW'(13) && kind_q == uarf_pkg::KIND_IPV4) begin
					if (p == PW'(14)) begin
						hl = {frame_byte[3:0], 2'b00};
						hlen_n = (hl < uarf_pkg::IP_HDR_MIN) ? uarf_pkg::IP_HDR_MIN : hl;
						hend = PW'(14) + {{(PW-6){1'b0}}, hlen_n};
					end
					if (p == PW'(23) && frame_byte != uarf_pkg::PROTO_UDP) begin
						drop_n = uarf_pkg::ST_TYPE_DROP;
					end
					if (drop_n == uarf_pkg::ST_PENDING && p >= PW'(30) && p <= PW'(33)
						&& frame_byte != ip_byte) begin
						drop_n = uarf_pkg::ST_IP_DROP;
					end
					if (p < hend) begin
						if (p[0]) begin
							sum1 = {1'b0, csum_q} + {1'b0, shift_n[15:0]};
							sum2 = {1'b0, sum1[15:0]} + {16'd0, sum1[16]};
							csum_n = sum2[15:0] + {15'd0, sum2[16]};
						end
						if (drop_n == uarf_pkg::ST_PENDING && p == hend - PW'(1)
							&& csum_n != 16'hFFFF) begin
							drop_n = uarf_pkg::ST_CSUM_DROP;
						end
					end else if (drop_n == uarf_pkg::ST_PENDING) begin
						u = p - hend;
						if (u == PW'(3) && shift_n[15:0] != cfg.local_port) begin
							drop_n = uarf_pkg::ST_PORT_DROP;
						end else if (u == PW'(5)) begin
							udp_n = shift_n[15:0];
							drop_n = uarf_pkg::ST_UDP_OK;
						end
					end
				end
			end
		end

		n = {{(PW-IDX_W){1'b0}}, idx_n};
		if (n < PW'(6)) trunc = uarf_pkg::ST_MAC_DROP;
		else if (kind_n == uarf_pkg::KIND_UNKNOWN) trunc = uarf_pkg::ST_TYPE_DROP;
		else if (kind_n == uarf_pkg::KIND_ARP) trunc = uarf_pkg::ST_IP_DROP;
		else if (n < PW'(24)) trunc = uarf_pkg::ST_TYPE_DROP;
		else if (n < PW'(34)) trunc = uarf_pkg::ST_IP_DROP;
		else if (n < PW'(14) + {{(PW-6){1'b0}}, hlen_n}) trunc = uarf_pkg::ST_CSUM_DROP;
		else trunc = uarf_pkg::ST_PORT_DROP;

		plen_n = (udp_n >= 16'd8) ? udp_n - 16'd8 : 16'd0;
		result.payload_byte = result.payload_valid ? frame_byte : 8'd0;
		result.frame_done = frame_end;
		result.remote_mac = mac_n;
		result.payload_length = (drop_n == uarf_pkg::ST_UDP_OK) ? plen_n : 16'd0;
		if (frame_end) begin
			result.frame_status = (drop_n != uarf_pkg::ST_PENDING) ? drop_n : trunc;
		end else begin
			result.frame_status = uarf_pkg::ST_PENDING;
		end

		if (step && frame_end) begin
			idx_n = '0;
			shift_n = '0;
			csum_n = '0;
			hlen_n = uarf_pkg::IP_HDR_MIN;
			udp_n = '0;
			drop_n = uarf_pkg::ST_PENDING;
			kind_n = uarf_pkg::KIND_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			shift_q <= '0;
			csum_q <= '0;
			hlen_q <= uarf_pkg::IP_HDR_MIN;
			udp_q <= '0;
			drop_q <= uarf_pkg::ST_PENDING;
			kind_q <= uarf_pkg::KIND_UNKNOWN;
			mac_q <= '0;
		end else if (step) begin
			idx_q <= idx_n;
			shift_q <= shift_n;
			csum_q <= csum_n;
			hlen_q <= hlen_n;
			udp_q <= udp_n;
			drop_q <= drop_n;
			kind_q <= kind_n;
			mac_q <= mac_n;
		end
	end

endmodule

// File: hw/rtl/udp_arp_receive_filter.sv
// Top level of the UDP/ARP receive filter: input register, output register, handshakes.
// Depends on uarf_pkg, uarf_cfg_regs and uarf_parser.
//
// The input channel (in_valid/in_ready) takes one Ethernet frame byte per transaction,
// destination MAC first, with frame_end set on the final byte. The output channel
// (out_valid/out_ready) returns exactly one result transaction per input byte:
// the byte itself when it belongs to an accepted UDP payload, the frame status on
// the final byte, the last MAC learned from ARP and the payload length.
// An accepted byte is held in the input register and is parsed as it moves into the
// output register. One byte per cycle is sustained while out_ready stays high, as set
// by the single input and output register pair around the parser. When out_ready is
// low, the output register holds its result and the input register holds one more
// byte, after which in_ready drops until the output side drains. Reset clears both
// registers, the frame state and the learned MAC, and loads the configuration defaults.
// The configuration port (cfg_write, cfg_index, cfg_data) writes one register per
// cycle; the user must write only while the block idles; the block does not enforce it.
module udp_arp_receive_filter #(
	parameter int MAX_FRAME_BYTES = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [uarf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [uarf_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] frame_byte,
	input logic frame_end,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] payload_byte,
	output logic payload_valid,
	output logic frame_done,
	output logic [2:0] frame_status,
	output logic [47:0] remote_mac,
	output logic [15:0] payload_length
);

	uarf_pkg::cfg_t cfg;
	uarf_pkg::result_t result;
	uarf_pkg::result_t result_q;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic end_s1;
	logic out_valid_q;
	logic advance;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	uarf_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	uarf_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.frame_byte(byte_s1),
		.frame_end(end_s1),
		.cfg(cfg),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1 <= '0;
			end_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
			byte_s1 <= frame_byte;
			end_s1 <= frame_end;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			result_q <= '0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			result_q <= result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign payload_byte = result_q.payload_byte;
	assign payload_valid = result_q.payload_valid;
	assign frame_done = result_q.frame_done;
	assign frame_status = result_q.frame_status;
	assign remote_mac = result_q.remote_mac;
	assign payload_length = result_q.payload_length;

`ifndef SYNTHESIS
	a_mid_frame_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_done |-> frame_status == uarf_pkg::ST_PENDING)
		else $error("Status reported before the final byte of a frame.");

	a_payload_final_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done && (payload_valid || payload_length != 16'd0)
		|-> frame_status == uarf_pkg::ST_UDP_OK)
		else $error("Payload on a frame that did not end as accepted UDP.");

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == 8'd0)
		else $error("Payload byte not cleared outside a payload.");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(end_s1))
		else $error("Input register lost a transaction while stalled.");
`endif

endmodule

// File: test/tb_udp_arp_receive_filter.sv
// Self-checking testbench for udp_arp_receive_filter: builds Ethernet, ARP and IPv4/UDP frames,
// drives them byte by byte with random idling and compares every result with an in-bench model.
// Depends on uarf_pkg and the udp_arp_receive_filter RTL.
module tb_udp_arp_receive_filter;

	localparam int FRAME_LIMIT = 4096;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		bit [47:0] dst_mac;
		bit [31:0] dst_ip;
		bit [15:0] dst_port;
		int n_payload;
		int ihl;
		bit [7:0] proto;
		bit bad_csum;
		int udp_len;
		int trailing;
	} udp_spec_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [uarf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [uarf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] frame_byte = 8'h00;
	logic frame_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] payload_byte;
	logic payload_valid;
	logic frame_done;
	logic [2:0] frame_status;
	logic [47:0] remote_mac;
	logic [15:0] payload_length;

	udp_arp_receive_filter #(.MAX_FRAME_BYTES(FRAME_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.payload_valid(payload_valid),
		.frame_done(frame_done),
		.frame_status(frame_status),
		.remote_mac(remote_mac),
		.payload_length(payload_length)
	);

	uarf_pkg::cfg_t regs;
	int frame_pos;
	bit [63:0] hdr_window;
	int hdr_sum;
	int ip_hdr_bytes;
	int udp_len_field;
	uarf_pkg::status_t verdict;
	uarf_pkg::kind_t kind;
	bit [47:0] arp_peer_mac;

	uarf_pkg::result_t byte_results[$];
	bit [7:0] frame_q[$];
	int items_sent = 0;
	int results_seen = 0;
	int frames_sent = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int ready_mode = 0;
	int ready_run = 0;
	int streamed = 0;
	int status_seen[8];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int ones_fold(int v);
		v = (v & 'hFFFF) + (v >> 16);
		v = (v & 'hFFFF) + (v >> 16);
		return v;
	endfunction

	function automatic int payload_bytes_due();
		return udp_len_field >= 8 ? udp_len_field - 8 : 0;
	endfunction

	function automatic void restart_frame();
		frame_pos = 0;
		hdr_window = '0;
		hdr_sum = 0;
		ip_hdr_bytes = 20;
		udp_len_field = 0;
		verdict = uarf_pkg::ST_PENDING;
		kind = uarf_pkg::KIND_UNKNOWN;
	endfunction

	function automatic uarf_pkg::status_t early_end_status();
		if (frame_pos < 6) return uarf_pkg::ST_MAC_DROP;
		if (kind == uarf_pkg::KIND_UNKNOWN) return uarf_pkg::ST_TYPE_DROP;
		if (kind == uarf_pkg::KIND_ARP) return uarf_pkg::ST_IP_DROP;
		if (frame_pos < 24) return uarf_pkg::ST_TYPE_DROP;
		if (frame_pos < 34) return uarf_pkg::ST_IP_DROP;
		if (frame_pos < 14 + ip_hdr_bytes) return uarf_pkg::ST_CSUM_DROP;
		return uarf_pkg::ST_PORT_DROP;
	endfunction

	function automatic bit parse_byte(int p, bit [7:0] b);
		int hend;
		int hl;
		int start;
		bit [15:0] w;
		if (!(kind == uarf_pkg::KIND_ARP && p >= 28))
			hdr_window = {hdr_window[55:0], b};
		w = hdr_window[15:0];
		if (verdict == uarf_pkg::ST_UDP_OK) begin
			start = 14 + ip_hdr_bytes + 8;
			return p >= start && (p - start) < payload_bytes_due();
		end
		if (verdict != uarf_pkg::ST_PENDING)
			return 1'b0;
		if (p < 6) begin
			if (b != regs.local_mac[8*(5-p) +: 8])
				verdict = uarf_pkg::ST_MAC_DROP;
		end else if (p == 13) begin
			if (w == uarf_pkg::ETH_TYPE_ARP)
				kind = uarf_pkg::KIND_ARP;
			else if (w == uarf_pkg::ETH_TYPE_IPV4 && regs.accept_udp)
				kind = uarf_pkg::KIND_IPV4;
			else
				verdict = uarf_pkg::ST_TYPE_DROP;
		end else if (kind == uarf_pkg::KIND_ARP) begin
			if (p >= 38 && p <= 41) begin
				if (b != regs.local_ip[8*(41-p) +: 8]) begin
					verdict = uarf_pkg::ST_IP_DROP;
				end else if (p == 41) begin
					arp_peer_mac = hdr_window[47:0];
					verdict = uarf_pkg::ST_ARP_LEARNED;
				end
			end
		end else if (kind == uarf_pkg::KIND_IPV4) begin
			if (p == 14) begin
				hl = 4 * int'(b[3:0]);
				ip_hdr_bytes = hl < 20 ? 20 : hl;
			end
			hend = 14 + ip_hdr_bytes;
			if (p == 23 && b != uarf_pkg::PROTO_UDP)
				verdict = uarf_pkg::ST_TYPE_DROP;
			if (verdict == uarf_pkg::ST_PENDING && p >= 30 && p <= 33 &&
					b != regs.local_ip[8*(33-p) +: 8])
				verdict = uarf_pkg::ST_IP_DROP;
			if (p < hend) begin
				if (((p - 14) & 1) != 0)
					hdr_sum = ones_fold(hdr_sum + int'(w));
				if (verdict == uarf_pkg::ST_PENDING && p == hend - 1 && hdr_sum != 'hFFFF)
					verdict = uarf_pkg::ST_CSUM_DROP;
			end else if (verdict == uarf_pkg::ST_PENDING) begin
				if (p - hend == 3 && w != regs.local_port) begin
					verdict = uarf_pkg::ST_PORT_DROP;
				end else if (p - hend == 5) begin
					udp_len_field = int'(w);
					verdict = uarf_pkg::ST_UDP_OK;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic uarf_pkg::result_t filter_byte(bit [7:0] b, bit last);
		uarf_pkg::result_t r;
		bit took;
		took = 1'b0;
		if (frame_pos < FRAME_LIMIT) begin
			took = parse_byte(frame_pos, b);
			frame_pos++;
		end
		r.payload_byte = took ? b : 8'h00;
		r.payload_valid = took;
		r.frame_done = last;
		if (!last)
			r.frame_status = uarf_pkg::ST_PENDING;
		else if (verdict != uarf_pkg::ST_PENDING)
			r.frame_status = verdict;
		else
			r.frame_status = early_end_status();
		r.remote_mac = arp_peer_mac;
		r.payload_length = (verdict == uarf_pkg::ST_UDP_OK) ? 16'(payload_bytes_due()) : 16'h0000;
		if (last)
			restart_frame();
		return r;
	endfunction

	function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 100)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk) begin : scoreboard
		uarf_pkg::result_t want;
		if (arst_n && in_valid && in_ready)
			byte_results.push_back(filter_byte(frame_byte, frame_end));
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (byte_results.size() == 0) begin
				fail_count++;
				$display("%0t: result transaction with nothing outstanding", $time);
			end else begin
				want = byte_results.pop_front();
				check_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte));
				check_field("payload_valid", 64'(want.payload_valid), 64'(payload_valid));
				check_field("frame_done", 64'(want.frame_done), 64'(frame_done));
				check_field("frame_status", 64'(want.frame_status), 64'(frame_status));
				check_field("remote_mac", 64'(want.remote_mac), 64'(remote_mac));
				check_field("payload_length", 64'(want.payload_length), 64'(payload_length));
				if (want.frame_done)
					status_seen[want.frame_status]++;
				if (want.payload_valid)
					streamed++;
			end
		end
	end

	always @(posedge clk) begin
		if (ready_run == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_run = $urandom_range(1, 40);
		end else begin
			ready_run--;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ready_run[2];
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("udp_arp_receive_filter verification failed");
			$finish;
		end
	end

	function automatic bit [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	task automatic send_byte(bit [7:0] b, bit last);
		in_valid <= 1'b1;
		frame_byte <= b;
		frame_end <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
		frames_sent++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (results_seen < items_sent)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [uarf_pkg::CFG_INDEX_W-1:0] idx,
			logic [uarf_pkg::CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_config(bit [47:0] mac, bit [31:0] ip, bit [15:0] port, bit acc);
		write_reg(uarf_pkg::CFG_LOCAL_MAC, mac);
		write_reg(uarf_pkg::CFG_LOCAL_IP, {16'($urandom), ip});
		write_reg(uarf_pkg::CFG_LOCAL_PORT, {32'($urandom), port});
		write_reg(uarf_pkg::CFG_ACCEPT_UDP, {47'(rand48()), acc});
		cfg_write <= 1'b0;
		@(posedge clk);
		regs.local_mac = mac;
		regs.local_ip = ip;
		regs.local_port = port;
		regs.accept_udp = acc;
	endtask

	task automatic push_bytes(bit [63:0] v, int nb);
		for (int i = nb - 1; i >= 0; i--)
			frame_q.push_back(v[8*i +: 8]);
	endtask

	task automatic cut_frame(int len);
		while (frame_q.size() > len)
			void'(frame_q.pop_back());
	endtask

	task automatic build_eth(bit [47:0] dst, bit [15:0] eth_type);
		frame_q.delete();
		push_bytes(64'(dst), 6);
		push_bytes(64'(rand48()), 6);
		push_bytes(64'(eth_type), 2);
	endtask

	function automatic udp_spec_t good_udp(int n);
		udp_spec_t s;
		s.dst_mac = regs.local_mac;
		s.dst_ip = regs.local_ip;
		s.dst_port = regs.local_port;
		s.n_payload = n;
		s.ihl = 5;
		s.proto = uarf_pkg::PROTO_UDP;
		s.bad_csum = 1'b0;
		s.udp_len = n + 8;
		s.trailing = 0;
		return s;
	endfunction

	task automatic build_udp(udp_spec_t s);
		bit [7:0] hdr [60];
		int hl;
		int sum;
		bit [15:0] csum;
		hl = (s.ihl < 5) ? 20 : 4 * s.ihl;
		build_eth(s.dst_mac, uarf_pkg::ETH_TYPE_IPV4);
		for (int i = 0; i < hl; i++)
			hdr[i] = 8'($urandom);
		hdr[0] = {4'h4, 4'(s.ihl)};
		{hdr[2], hdr[3]} = 16'(hl + 8 + s.n_payload);
		hdr[9] = s.proto;
		{hdr[10], hdr[11]} = 16'h0000;
		{hdr[16], hdr[17], hdr[18], hdr[19]} = s.dst_ip;
		sum = 0;
		for (int i = 0; i < hl; i += 2)
			sum = ones_fold(sum + int'({hdr[i], hdr[i+1]}));
		csum = ~16'(sum);
		if (s.bad_csum)
			csum ^= 16'h0001 << $urandom_range(0, 15);
		{hdr[10], hdr[11]} = csum;
		for (int i = 0; i < hl; i++)
			frame_q.push_back(hdr[i]);
		push_bytes(64'($urandom), 2);
		push_bytes(64'(s.dst_port), 2);
		push_bytes(64'(s.udp_len), 2);
		push_bytes(64'($urandom), 2);
		repeat (s.n_payload + s.trailing) frame_q.push_back(8'($urandom));
	endtask

	task automatic build_arp(bit [47:0] dst, bit [47:0] sender, bit [31:0] target, int pad);
		build_eth(dst, uarf_pkg::ETH_TYPE_ARP);
		push_bytes(64'h0001_0800_0604, 6);
		push_bytes(64'($urandom_range(1, 2)), 2);
		push_bytes(64'(sender), 6);
		push_bytes(64'($urandom), 4);
		push_bytes(64'(rand48()), 6);
		push_bytes(64'(target), 4);
		repeat (pad) frame_q.push_back(8'($urandom));
	endtask

	task automatic test_reset_defaults();
		build_udp(good_udp(4));
		send_frame();
		build_arp(regs.local_mac, 48'hA5C3_0F96_5A3C, regs.local_ip, 0);
		send_frame();
	endtask

	task automatic test_mac_filter();
		udp_spec_t s;
		s = good_udp(3);
		s.dst_mac[47:40] = ~s.dst_mac[47:40];
		build_udp(s);
		send_frame();
		s = good_udp(3);
		s.dst_mac[0] = ~s.dst_mac[0];
		build_udp(s);
		send_frame();
	endtask

	task automatic test_ethertypes();
		udp_spec_t s;
		build_eth(regs.local_mac, 16'h86DD);
		repeat (30) frame_q.push_back(8'($urandom));
		send_frame();
		s = good_udp(4);
		s.proto = 8'h06;
		build_udp(s);
		send_frame();
		wait_drain();
		set_config(regs.local_mac, regs.local_ip, regs.local_port, 1'b0);
		build_udp(good_udp(4));
		send_frame();
		build_arp(regs.local_mac, rand48(), regs.local_ip, 4);
		send_frame();
		wait_drain();
		set_config(regs.local_mac, regs.local_ip, regs.local_port, 1'b1);
	endtask

	task automatic test_udp_checks();
		udp_spec_t s;
		s = good_udp(5);
		s.dst_ip[31] = ~s.dst_ip[31];
		build_udp(s);
		send_frame();
		s = good_udp(5);
		s.bad_csum = 1'b1;
		build_udp(s);
		send_frame();
		s = good_udp(5);
		s.dst_port[15] = ~s.dst_port[15];
		build_udp(s);
		send_frame();
		s = good_udp(6);
		s.ihl = 0;
		build_udp(s);
		send_frame();
		s = good_udp(3);
		s.ihl = 4;
		build_udp(s);
		send_frame();
		s = good_udp(3);
		s.ihl = 15;
		build_udp(s);
		send_frame();
		s = good_udp(4);
		s.udp_len = 5;
		build_udp(s);
		send_frame();
		build_udp(good_udp(0));
		send_frame();
		s = good_udp(6);
		s.udp_len = 65535;
		build_udp(s);
		send_frame();
		s = good_udp(5);
		s.trailing = 7;
		build_udp(s);
		send_frame();
	endtask

	task automatic test_arp_learning();
		bit [31:0] other_ip;
		other_ip = regs.local_ip ^ 32'h0000_0100;
		build_arp(regs.local_mac, rand48(), other_ip, 0);
		send_frame();
		build_arp(regs.local_mac, rand48(), regs.local_ip, 18);
		send_frame();
	endtask

	task automatic test_truncation();
		int cuts[6] = '{1, 6, 14, 28, 33, 38};
		foreach (cuts[i]) begin
			build_udp(good_udp(8));
			cut_frame(cuts[i]);
			send_frame();
		end
		build_arp(regs.local_mac, rand48(), regs.local_ip, 0);
		cut_frame(35);
		send_frame();
	endtask

	task automatic test_config_extremes();
		wait_drain();
		set_config('1, '1, '1, 1'b1);
		build_udp(good_udp(2));
		send_frame();
		build_arp(regs.local_mac, '1, regs.local_ip, 0);
		send_frame();
		wait_drain();
		set_config('0, '0, '0, 1'b1);
		build_udp(good_udp(1));
		send_frame();
		build_arp(regs.local_mac, '0, regs.local_ip, 0);
		send_frame();
	endtask

	task automatic random_frame();
		udp_spec_t s;
		int pick;
		bit [31:0] target;
		bit [47:0] dst;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			s = good_udp(($urandom_range(0, 7) == 0) ? $urandom_range(17, 80)
				: $urandom_range(0, 16));
			if ($urandom_range(0, 11) == 0)
				s.dst_mac ^= 48'h1 << $urandom_range(0, 47);
			if ($urandom_range(0, 11) == 0)
				s.proto = 8'($urandom);
			if ($urandom_range(0, 11) == 0)
				s.dst_ip ^= 32'h1 << $urandom_range(0, 31);
			if ($urandom_range(0, 11) == 0)
				s.bad_csum = 1'b1;
			if ($urandom_range(0, 11) == 0)
				s.dst_port ^= 16'h1 << $urandom_range(0, 15);
			case ($urandom_range(0, 15))
				12, 13: s.ihl = $urandom_range(6, 15);
				14: s.ihl = $urandom_range(0, 4);
				default: s.ihl = 5;
			endcase
			case ($urandom_range(0, 9))
				0: s.udp_len = $urandom_range(0, 7);
				1: s.udp_len = s.n_payload + 8 + $urandom_range(1, 40);
				default: s.udp_len = s.n_payload + 8;
			endcase
			if ($urandom_range(0, 4) == 0)
				s.trailing = $urandom_range(1, 10);
			build_udp(s);
			if ($urandom_range(0, 9) == 0)
				cut_frame($urandom_range(1, frame_q.size()));
		end else if (pick < 75) begin
			dst = regs.local_mac;
			if ($urandom_range(0, 9) == 0)
				dst ^= 48'h1 << $urandom_range(0, 47);
			target = ($urandom_range(0, 4) == 0) ? $urandom : regs.local_ip;
			build_arp(dst, rand48(), target, $urandom_range(0, 18));
			if ($urandom_range(0, 9) == 0)
				cut_frame($urandom_range(1, frame_q.size()));
		end else if (pick < 85) begin
			build_eth(regs.local_mac, 16'($urandom));
			repeat ($urandom_range(0, 40)) frame_q.push_back(8'($urandom));
		end else begin
			frame_q.delete();
			repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
		end
		send_frame();
	endtask

	task automatic test_random_traffic(int budget, bit arp_only);
		bit [47:0] mac;
		int start;
		bit paused;
		wait_drain();
		case ($urandom_range(0, 3))
			0: mac = '0;
			1: mac = '1;
			default: mac = rand48();
		endcase
		set_config(mac, $urandom, 16'($urandom), !arp_only);
		start = items_sent;
		paused = 1'b0;
		while (items_sent - start < budget) begin
			random_frame();
			if (!paused && items_sent - start >= budget / 2) begin
				wait_drain();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		regs.local_mac = '0;
		regs.local_ip = uarf_pkg::LOCAL_IP_RESET;
		regs.local_port = uarf_pkg::LOCAL_PORT_RESET;
		regs.accept_udp = 1'b1;
		arp_peer_mac = '0;
		restart_frame();
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		wait_drain();
		set_config(48'h02_1A_2B_3C_4D_5E, 32'hC0A8_0A64, 16'd5005, 1'b1);
		test_mac_filter();
		test_ethertypes();
		test_udp_checks();
		test_arp_learning();
		test_truncation();
		test_config_extremes();
		test_random_traffic(60, 1'b0);
		test_random_traffic(40, 1'b1);
		test_random_traffic(60, 1'b0);
		wait_drain();
		repeat (8) @(posedge clk);
		if (byte_results.size() != 0) begin
			fail_count++;
			$display("%0t: %0d result transactions never arrived", $time, byte_results.size());
		end
		$display("Sent %0d frames (%0d bytes) over several register settings, %0d payload bytes out.",
			frames_sent, items_sent, streamed);
		$display("Outcomes: arp %0d, udp %0d, mac %0d, type %0d, ip %0d, checksum %0d, port %0d.",
			status_seen[uarf_pkg::ST_ARP_LEARNED], status_seen[uarf_pkg::ST_UDP_OK],
			status_seen[uarf_pkg::ST_MAC_DROP], status_seen[uarf_pkg::ST_TYPE_DROP],
			status_seen[uarf_pkg::ST_IP_DROP], status_seen[uarf_pkg::ST_CSUM_DROP],
			status_seen[uarf_pkg::ST_PORT_DROP]);
		if (fail_count == 0)
			$display("udp_arp_receive_filter verification clean");
		else
			$display("udp_arp_receive_filter verification failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/uarf_pkg.sv
hw/rtl/uarf_cfg_regs.sv
hw/rtl/uarf_parser.sv
hw/rtl/udp_arp_receive_filter.sv
test/tb_udp_arp_receive_filter.sv
